// ----- rtl/sobel_edge_threshold_stream_macros.svh -----
// Assertion macros shared by the Sobel edge threshold stream RTL.
// Included by rtl/sobel_edge_threshold_stream.sv; no other dependencies.
`ifndef SOBEL_EDGE_THRESHOLD_STREAM_MACROS_SVH
`define SOBEL_EDGE_THRESHOLD_STREAM_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SET_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define SET_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/sobel_pkg.sv -----
// Shared types and constants for the Sobel edge threshold stream.
// Used by rtl/sobel_edge_threshold_stream.sv; depends on nothing.
package sobel_pkg;

   // Configuration register indexes.
   localparam logic [1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_MAX_VALUE    = 2'd2;

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;

   // Widths of the configuration fields.
   localparam int WIDTH_FIELD_BITS  = 11;
   localparam int HEIGHT_FIELD_BITS = 13;
   localparam int LEVEL_BITS        = 8;

   // Reset values of the configuration registers.
   localparam int WIDTH_RESET  = 1024;
   localparam int HEIGHT_RESET = 1024;
   localparam logic [LEVEL_BITS-1:0] LEVEL_RESET = 8'd255;

   // Stream payload widths.
   localparam int REQ_DATA_BITS = 8;
   localparam int RSP_DATA_BITS = 32;
   localparam int CENTER_ROW_BITS = 12;
   localparam int CENTER_COL_BITS = 10;

   // Per-pixel bookkeeping carried down the pipeline.
   typedef struct packed {
      logic                       produce;
      logic                       frame_end;
      logic [CENTER_ROW_BITS-1:0] center_row;
      logic [CENTER_COL_BITS-1:0] center_col;
   } meta_type;

   // One result as it sits in the output register or the skid register.
   typedef struct packed {
      logic [LEVEL_BITS-1:0]      edge_value;
      logic [CENTER_ROW_BITS-1:0] center_row;
      logic [CENTER_COL_BITS-1:0] center_col;
      logic                       last_of_frame;
   } result_type;

endpackage

// ----- rtl/sobel_edge_threshold_stream.sv -----
// Top level of the streaming 3x3 Sobel edge detector with binary threshold.
// Depends on rtl/sobel_pkg.sv and rtl/sobel_edge_threshold_stream_macros.svh.
//
// Grey pixels enter in raster order on the req_ stream, one per request. Every
// pixel at row r >= 2 and column c >= 2 completes the window centered on
// (r-1, c-1) and yields one result on the rsp_ stream: max_value when
// |gx|+|gy| exceeds max_value, otherwise zero, with the center coordinates and
// tlast on the final interior result of the frame. Border pixels give nothing.
// The csr_ port writes image_width (0), image_height (1) and max_value (2);
// write it only while no request is in flight. csr_ready is always high.
// Throughput is one pixel per clock cycle while no result is parked in the skid
// register. An accepted pixel passes the registered row-store read, the window
// shift, and the sums and threshold that load the output register on rsp_.
// The two row stores are plain arrays, read at the column of the accepted pixel
// and written back at that column from stage 1 when the pipeline advances.
// When the receiver stalls, one result parks in a skid register and req_tready
// drops on the next cycle; the whole pipeline then holds until it drains.
// Reset (synchronous, active high) empties the pipeline, clears the position
// counters and restores the register defaults. The row stores are not cleared;
// the first two rows of a frame fill them before any result uses them.
`include "sobel_edge_threshold_stream_macros.svh"

module sobel_edge_threshold_stream
   import sobel_pkg::*;
#(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 4096,
   parameter int PIXEL_BITS = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   // Pixel stream.
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [REQ_DATA_BITS-1:0]  req_tdata,   // [7:0] pixel_value
   // Result stream.
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // [7:0] edge_value, [19:8] center_row, [29:20] center_col, [31:30] zero
   output logic [RSP_DATA_BITS-1:0]  rsp_tdata,
   output logic                      rsp_tlast,   // last_of_frame
   // Configuration writes.
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int COL_W = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
   localparam int ROW_W = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
   localparam int SUM_W = PIXEL_BITS + 4;
   localparam int CMP_W = (SUM_W > LEVEL_BITS) ? SUM_W : LEVEL_BITS;
   localparam int WIDTH_RST_CLAMP  = (MAX_WIDTH < WIDTH_RESET) ? MAX_WIDTH : WIDTH_RESET;
   localparam int HEIGHT_RST_CLAMP = (MAX_HEIGHT < HEIGHT_RESET) ? MAX_HEIGHT : HEIGHT_RESET;
   localparam logic [COL_W-1:0] COL_LAST_RST = COL_W'(WIDTH_RST_CLAMP - 1);
   localparam logic [ROW_W-1:0] ROW_LAST_RST = ROW_W'(HEIGHT_RST_CLAMP - 1);

   // ------------------------------------------------------------------
   // Configuration: sizes are clamped once, when written.
   // ------------------------------------------------------------------
   logic [COL_W-1:0]      col_last_ff;
   logic [COL_W-1:0]      col_last_in;
   logic [ROW_W-1:0]      row_last_ff;
   logic [ROW_W-1:0]      row_last_in;
   logic [LEVEL_BITS-1:0] max_value_ff;
   logic [31:0]           width_clamp;
   logic [31:0]           height_clamp;
   logic                  csr_write;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid & csr_ready;

   always_comb begin
      width_clamp  = 32'(csr_wdata[WIDTH_FIELD_BITS-1:0]);
      height_clamp = 32'(csr_wdata[HEIGHT_FIELD_BITS-1:0]);
      if (width_clamp < 32'd3) begin
         width_clamp = 32'd3;
      end else if (width_clamp > 32'(MAX_WIDTH)) begin
         width_clamp = 32'(MAX_WIDTH);
      end
      if (height_clamp < 32'd3) begin
         height_clamp = 32'd3;
      end else if (height_clamp > 32'(MAX_HEIGHT)) begin
         height_clamp = 32'(MAX_HEIGHT);
      end
      col_last_in = COL_W'(width_clamp - 32'd1);
      row_last_in = ROW_W'(height_clamp - 32'd1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_last_ff  <= COL_LAST_RST;
         row_last_ff  <= ROW_LAST_RST;
         max_value_ff <= LEVEL_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  col_last_ff  <= col_last_in;
            CSR_IMAGE_HEIGHT: row_last_ff  <= row_last_in;
            CSR_MAX_VALUE:    max_value_ff <= csr_wdata[LEVEL_BITS-1:0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Input stage: position counters and row-store read.
   // ------------------------------------------------------------------
   logic                  advance;
   logic                  accept;
   logic [COL_W-1:0]      col_ff;
   logic [COL_W-1:0]      col_in;
   logic [ROW_W-1:0]      row_ff;
   logic [ROW_W-1:0]      row_in;
   logic                  row_end;
   logic                  frame_end;
   logic [PIXEL_BITS-1:0] pixel;
   logic                  skid_valid_ff;

   // Everything moves together unless a result is parked in the skid register.
   assign advance    = ~skid_valid_ff;
   assign req_tready = advance;
   assign accept     = req_tvalid & req_tready;
   assign pixel      = PIXEL_BITS'(req_tdata[LEVEL_BITS-1:0]);
   assign row_end    = col_ff >= col_last_ff;
   assign frame_end  = row_end && (row_ff >= row_last_ff);

   always_comb begin
      col_in = col_ff + COL_W'(1);
      row_in = row_ff;
      if (row_end) begin
         col_in = '0;
         row_in = frame_end ? '0 : row_ff + ROW_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Stage 1 holds the accepted pixel and the two row-store words at its column.
   logic                  s1_valid_ff;
   logic [PIXEL_BITS-1:0] s1_pixel_ff;
   logic [COL_W-1:0]      s1_col_ff;
   meta_type              s1_meta_ff;
   logic [PIXEL_BITS-1:0] older_rd_ff;
   logic [PIXEL_BITS-1:0] newer_rd_ff;
   logic [PIXEL_BITS-1:0] older_mem [MAX_WIDTH];
   logic [PIXEL_BITS-1:0] newer_mem [MAX_WIDTH];

   always_ff @(posedge clock) begin
      if (accept) begin
         older_rd_ff <= older_mem[col_ff];
         newer_rd_ff <= newer_mem[col_ff];
      end
      // Write-back follows the read, from stage 1; successive pixels never share a column.
      if (advance && s1_valid_ff) begin
         older_mem[s1_col_ff] <= newer_rd_ff;
         newer_mem[s1_col_ff] <= s1_pixel_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pixel_ff           <= pixel;
         s1_col_ff             <= col_ff;
         s1_meta_ff.produce    <= (row_ff >= ROW_W'(2)) && (col_ff >= COL_W'(2));
         s1_meta_ff.frame_end  <= frame_end;
         s1_meta_ff.center_row <= CENTER_ROW_BITS'(row_ff - ROW_W'(1));
         s1_meta_ff.center_col <= CENTER_COL_BITS'(col_ff - COL_W'(1));
      end
   end

   // ------------------------------------------------------------------
   // Stage 2: the 3x3 window, row-major with index 0 at top left.
   // ------------------------------------------------------------------
   logic                  s2_valid_ff;
   meta_type              s2_meta_ff;
   logic [PIXEL_BITS-1:0] win_ff [9];

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s1_valid_ff) begin
         for (int k = 0; k < 3; k++) begin
            win_ff[k*3]     <= win_ff[k*3 + 1];
            win_ff[k*3 + 1] <= win_ff[k*3 + 2];
         end
         win_ff[2]  <= older_rd_ff;
         win_ff[5]  <= newer_rd_ff;
         win_ff[8]  <= s1_pixel_ff;
         s2_meta_ff <= s1_meta_ff;
      end
   end

   // Sobel sums, Manhattan magnitude and threshold.
   logic signed [SUM_W-1:0] win_s [9];
   logic signed [SUM_W-1:0] gx;
   logic signed [SUM_W-1:0] gy;
   logic signed [SUM_W-1:0] abs_gx;
   logic signed [SUM_W-1:0] abs_gy;
   logic [SUM_W-1:0]        magnitude;
   logic [LEVEL_BITS-1:0]   edge_level;
   logic                    push;
   result_type              result;

   always_comb begin
      for (int k = 0; k < 9; k++) begin
         win_s[k] = signed'(SUM_W'(win_ff[k]));
      end
      gx = win_s[2] - win_s[0] + ((win_s[5] - win_s[3]) <<< 1) + win_s[8] - win_s[6];
      gy = win_s[6] + (win_s[7] <<< 1) + win_s[8]
         - win_s[0] - (win_s[1] <<< 1) - win_s[2];
      abs_gx     = gx[SUM_W-1] ? -gx : gx;
      abs_gy     = gy[SUM_W-1] ? -gy : gy;
      magnitude  = unsigned'(abs_gx) + unsigned'(abs_gy);
      edge_level = (CMP_W'(magnitude) > CMP_W'(max_value_ff)) ? max_value_ff : '0;
      result.edge_value    = edge_level;
      result.center_row    = s2_meta_ff.center_row;
      result.center_col    = s2_meta_ff.center_col;
      result.last_of_frame = s2_meta_ff.frame_end;
   end

   assign push = advance && s2_valid_ff && s2_meta_ff.produce;

   // ------------------------------------------------------------------
   // Output register with a one-entry skid register behind it.
   // ------------------------------------------------------------------
   logic       rsp_valid_ff;
   result_type rsp_data_ff;
   result_type skid_data_ff;
   logic       pop;

   assign pop = rsp_valid_ff & rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (push) begin
         if (rsp_valid_ff && !pop) begin
            skid_valid_ff <= 1'b1;
         end
         rsp_valid_ff <= 1'b1;
      end else if (pop) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (pop) begin
            rsp_data_ff <= skid_data_ff;
         end
      end else if (push) begin
         if (rsp_valid_ff && !pop) begin
            skid_data_ff <= result;
         end else begin
            rsp_data_ff <= result;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_data_ff.last_of_frame;
   assign rsp_tdata  = RSP_DATA_BITS'({rsp_data_ff.center_col,
                                       rsp_data_ff.center_row,
                                       rsp_data_ff.edge_value});

   // ------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------
   `SET_ASSERT_IMPLIES(a_skid_behind_rsp, clock, reset, skid_valid_ff, rsp_valid_ff, "skid register holds a result while the output register is empty")
   `SET_ASSERT_NEXT(a_skid_holds, clock, reset, skid_valid_ff && !rsp_tready, skid_valid_ff && rsp_valid_ff, "parked result lost while the receiver stalls")
   `SET_ASSERT_NEXT(a_stage_moves, clock, reset, s1_valid_ff && advance, s2_valid_ff, "pixel dropped between row-store read and window")
   `SET_ASSERT_NEXT(a_frame_wrap, clock, reset, accept && frame_end, (row_ff == '0) && (col_ff == '0), "position counters did not wrap at the end of the frame")

endmodule
